[rtl/tah_pkg.sv]
// Shared types and constants for the transformed bounding-box hull block.
package tah_pkg;

  localparam int COORD_W       = 32;
  localparam int ENTRY_W       = 20;
  localparam int NUM_AXES      = 3;
  localparam int ROW_W         = NUM_AXES * ENTRY_W;
  localparam int MAT_FRAC_BITS = 16;
  localparam int PROD_W        = ENTRY_W + COORD_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int CFG_ADDR_W    = 6;
  localparam int CFG_DATA_W    = 64;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  // Identity rows: one Q4.16 entry of 1.0 on the diagonal.
  localparam logic [ROW_W-1:0] ONE_ENTRY = ROW_W'(1) << MAT_FRAC_BITS;

  typedef enum logic [2:0] {
    REG_MATRIX_X = 3'd0,
    REG_MATRIX_Y = 3'd1,
    REG_MATRIX_Z = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_BOX    = 1'b1
  } op_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } out_item_t;

endpackage

[rtl/transformed_aabb_hull.sv]
// Top level of the transformed bounding-box hull block.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------
//  in        | in        | in_valid_i / in_stall_o   | in_item_i
//  out       | out       | out_valid_o / out_stall_i | out_item_o
//  config    | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One item enters per cycle while in_stall_o is low. Results reach the result register
// over four register stages: input register, nine 20x32 products, row sums with
// rounding, then running min/max fold plus translation. A vertex not marked last gives
// no result. Reset clears every stage valid, loads the identity map, zero offsets and
// an empty running box. A stalled output only holds the stages behind it once they are
// full; empty stages keep filling.
module transformed_aabb_hull (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tah_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tah_pkg::out_item_t               out_item_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tah_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tah_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tah_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import tah_pkg::*;

  localparam logic signed [SUM_W:0] SAT_HI = {{(SUM_W + 1 - COORD_W){1'b0}}, COORD_MAX};
  localparam logic signed [SUM_W:0] SAT_LO = {{(SUM_W + 1 - COORD_W){1'b1}}, COORD_MIN};
  localparam logic signed [SUM_W:0] BIAS_VERT = (SUM_W + 1)'(1) << (MAT_FRAC_BITS - 1);
  localparam logic signed [SUM_W:0] BIAS_BOX  = (SUM_W + 1)'(1) << MAT_FRAC_BITS;

  // Round to nearest with ties up, then saturate to the coordinate range; with half set the sum is also halved.
  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [SUM_W-1:0] s,
    input logic                    half
  );
    logic signed [SUM_W:0] b;
    logic signed [SUM_W:0] q;
    b = {s[SUM_W-1], s} + (half ? BIAS_BOX : BIAS_VERT);
    q = half ? (b >>> (MAT_FRAC_BITS + 1)) : (b >>> MAT_FRAC_BITS);
    if (q > SAT_HI) begin
      return COORD_MAX;
    end else if (q < SAT_LO) begin
      return COORD_MIN;
    end
    return q[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] add_sat(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [ROW_W-1:0]          matrix_q [NUM_AXES];
  logic signed [COORD_W-1:0] offset_q [NUM_AXES];
  logic                      cfg_wr;
  cfg_reg_e                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        matrix_q[r] <= ONE_ENTRY << (r * ENTRY_W);
        offset_q[r] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MATRIX_X: matrix_q[0] <= pwdata[ROW_W-1:0];
        REG_MATRIX_Y: matrix_q[1] <= pwdata[ROW_W-1:0];
        REG_MATRIX_Z: matrix_q[2] <= pwdata[ROW_W-1:0];
        REG_OFFSET_X: offset_q[0] <= pwdata[COORD_W-1:0];
        REG_OFFSET_Y: offset_q[1] <= pwdata[COORD_W-1:0];
        REG_OFFSET_Z: offset_q[2] <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MATRIX_X: prdata = CFG_DATA_W'(matrix_q[0]);
      REG_MATRIX_Y: prdata = CFG_DATA_W'(matrix_q[1]);
      REG_MATRIX_Z: prdata = CFG_DATA_W'(matrix_q[2]);
      REG_OFFSET_X: prdata = {{(CFG_DATA_W - COORD_W){1'b0}}, offset_q[0]};
      REG_OFFSET_Y: prdata = {{(CFG_DATA_W - COORD_W){1'b0}}, offset_q[1]};
      REG_OFFSET_Z: prdata = {{(CFG_DATA_W - COORD_W){1'b0}}, offset_q[2]};
      default:      prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic ready1, ready2, ready3, out_ready;
  logic s3_emit, s3_take;

  logic  s2_op_q, s2_last_q, s3_op_q, s3_last_q;
  in_item_t  s1_item_q;
  out_item_t out_item_q, out_item_d;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign ready3     = !s3_valid_q || out_ready;
  assign ready2     = !s2_valid_q || ready3;
  assign ready1     = !s1_valid_q || ready2;
  assign in_stall_o = !ready1;
  assign s3_emit    = (s3_op_q == OP_BOX) || s3_last_q;
  assign s3_take    = s3_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready1) s1_valid_q <= in_valid_i;
      if (ready2) s2_valid_q <= s1_valid_q;
      if (ready3) s3_valid_q <= s2_valid_q;
      if (out_ready) out_valid_q <= s3_valid_q && s3_emit;
    end
  end

  // ---------------- stage 1: input register ----------------
  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) s1_item_q <= in_item_i;
  end

  // ---------------- stage 2: products ----------------
  logic signed [COORD_W-1:0] s1_coord [NUM_AXES];
  logic signed [PROD_W-1:0]  prod_q   [NUM_AXES][NUM_AXES];

  assign s1_coord[0] = s1_item_q.coord_x;
  assign s1_coord[1] = s1_item_q.coord_y;
  assign s1_coord[2] = s1_item_q.coord_z;

  always_ff @(posedge clk_i) begin
    if (ready2 && s1_valid_q) begin
      s2_op_q   <= s1_item_q.operation;
      s2_last_q <= s1_item_q.last_vertex;
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          prod_q[r][c] <= PROD_W'($signed(matrix_q[r][c*ENTRY_W +: ENTRY_W])) *
                          PROD_W'(s1_coord[c]);
        end
      end
    end
  end

  // ---------------- stage 3: row sums, rounding ----------------
  logic signed [COORD_W-1:0] lo_d [NUM_AXES];
  logic signed [COORD_W-1:0] hi_d [NUM_AXES];
  logic signed [COORD_W-1:0] lo_q [NUM_AXES];
  logic signed [COORD_W-1:0] hi_q [NUM_AXES];

  always_comb begin
    logic signed [SUM_W-1:0]  vsum;
    logic signed [SUM_W-1:0]  asum;
    logic signed [PROD_W-1:0] mag;
    for (int r = 0; r < NUM_AXES; r++) begin
      vsum = '0;
      asum = '0;
      for (int c = 0; c < NUM_AXES; c++) begin
        mag  = prod_q[r][c][PROD_W-1] ? -prod_q[r][c] : prod_q[r][c];
        vsum = vsum + SUM_W'(prod_q[r][c]);
        asum = asum + SUM_W'(mag);
      end
      // A box's corner extremes are plus and minus half the sum of magnitudes.
      if (s2_op_q == OP_BOX) begin
        hi_d[r] = round_sat(asum, 1'b1);
        lo_d[r] = round_sat(-asum, 1'b1);
      end else begin
        hi_d[r] = round_sat(vsum, 1'b0);
        lo_d[r] = hi_d[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && s2_valid_q) begin
      s3_op_q   <= s2_op_q;
      s3_last_q <= s2_last_q;
      for (int r = 0; r < NUM_AXES; r++) begin
        lo_q[r] <= lo_d[r];
        hi_q[r] <= hi_d[r];
      end
    end
  end

  // ---------------- stage 4: running fold and translation ----------------
  logic signed [COORD_W-1:0] run_min_q [NUM_AXES];
  logic signed [COORD_W-1:0] run_max_q [NUM_AXES];
  logic signed [COORD_W-1:0] fold_min  [NUM_AXES];
  logic signed [COORD_W-1:0] fold_max  [NUM_AXES];
  logic signed [COORD_W-1:0] res_lo    [NUM_AXES];
  logic signed [COORD_W-1:0] res_hi    [NUM_AXES];

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      fold_min[r] = (lo_q[r] < run_min_q[r]) ? lo_q[r] : run_min_q[r];
      fold_max[r] = (hi_q[r] > run_max_q[r]) ? hi_q[r] : run_max_q[r];
      if (s3_op_q == OP_BOX) begin
        res_lo[r] = add_sat(lo_q[r], offset_q[r]);
        res_hi[r] = add_sat(hi_q[r], offset_q[r]);
      end else begin
        res_lo[r] = add_sat(fold_min[r], offset_q[r]);
        res_hi[r] = add_sat(fold_max[r], offset_q[r]);
      end
    end
    out_item_d.min_x = res_lo[0];
    out_item_d.min_y = res_lo[1];
    out_item_d.min_z = res_lo[2];
    out_item_d.max_x = res_hi[0];
    out_item_d.max_y = res_hi[1];
    out_item_d.max_z = res_hi[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        run_min_q[r] <= COORD_MAX;
        run_max_q[r] <= COORD_MIN;
      end
    end else if (s3_take && (s3_op_q == OP_VERTEX)) begin
      // Clear the running box once the last vertex has been folded in.
      for (int r = 0; r < NUM_AXES; r++) begin
        run_min_q[r] <= s3_last_q ? COORD_MAX : fold_min[r];
        run_max_q[r] <= s3_last_q ? COORD_MIN : fold_max[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_take && s3_emit) out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------- assertions ----------------
  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.min_x <= out_item_o.max_x) &&
                    (out_item_o.min_y <= out_item_o.max_y) &&
                    (out_item_o.min_z <= out_item_o.max_z))
    else $error("result box has min above max");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_take && (s3_op_q == OP_VERTEX) && s3_last_q) |=>
      (run_min_q[0] == COORD_MAX) && (run_max_q[0] == COORD_MIN) &&
      (run_min_q[2] == COORD_MAX) && (run_max_q[2] == COORD_MIN))
    else $error("running box not cleared after last vertex");

  a_no_emit_mid_hull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && out_ready && !s3_emit) |=> !out_valid_o)
    else $error("result produced for a vertex not marked last");

  a_box_keeps_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_take && (s3_op_q == OP_BOX)) |=>
      $stable(run_min_q[1]) && $stable(run_max_q[1]))
    else $error("box item disturbed the running box");

endmodule
